@@ sv/per_cpu_page_allocator_assert.svh @@
// assertion macros for the per-cpu page allocator checker
`ifndef PER_CPU_PAGE_ALLOCATOR_ASSERT_SVH
`define PER_CPU_PAGE_ALLOCATOR_ASSERT_SVH

// same-cycle implication
`define PCPA_ASSERT_NOW(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// next-cycle implication
`define PCPA_ASSERT_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

@@ sv/pcpa_pkg.sv @@
// package: shared constants, codes and controller/datapath types of the page allocator
package pcpa_pkg;

    localparam int NUM_CPUS_DEF   = 8;
    localparam int NUM_PAGES_DEF  = 1024;
    localparam int PAGE_SHIFT_DEF = 12;

    localparam int ADDR_W   = 32;
    localparam int CPU_IN_W = 3;
    localparam int BASE_W   = 20;
    localparam int TOP_W    = 21;
    localparam int CFG_W    = 21;
    localparam int CFG_IDX_W = 1;
    localparam int STATUS_W = 2;

    typedef enum logic
    {
        OP_ALLOC = 1'b0,
        OP_FREE  = 1'b1
    } op_t;

    localparam logic [STATUS_W-1:0] STATUS_OK      = 2'd0;
    localparam logic [STATUS_W-1:0] STATUS_NOMEM   = 2'd1;
    localparam logic [STATUS_W-1:0] STATUS_BADADDR = 2'd2;

    localparam logic [CFG_IDX_W-1:0] CFG_BASE_PAGE = 1'b0;
    localparam logic [CFG_IDX_W-1:0] CFG_TOP_PAGE  = 1'b1;

    typedef enum logic
    {
        S_IDLE,
        S_POP
    } state_t;

    typedef struct packed
    {
        logic take;
        logic pop;
    } cmd_t;

    typedef struct packed
    {
        logic alloc_hit;
    } sts_t;

endpackage

@@ sv/per_cpu_page_allocator.sv @@
// top level: per-cpu free-list page allocator with stealing
//
// request channel: start with op, cpu and address; a transfer happens at a
// rising edge with start high and busy low.
// result channel: done strobes for one cycle with status and page_address;
// the receiver takes it in that cycle and cannot stall the block.
// configuration: cfg_write with cfg_index (0 base_page, 1 top_page) and
// cfg_data, taken at any edge with cfg_write high; the user writes only
// while idle, the block does not enforce it. free: checked and pushed in
// the accept cycle, result in the next cycle; the next request may follow
// at once. allocate: pops the own list, else the lowest-numbered list with
// a page; the link memory read is registered, so a hit runs S_IDLE then
// S_POP (busy high in S_POP) and the result strobes in the cycle after the
// pop. out of memory gives status 1 in the cycle after accept.
// reset empties all lists and clears base_page and top_page; the link
// memory needs no clearing since only written links are ever followed.
module per_cpu_page_allocator
#(
    parameter int NUM_CPUS   = pcpa_pkg::NUM_CPUS_DEF,
    parameter int NUM_PAGES  = pcpa_pkg::NUM_PAGES_DEF,
    parameter int PAGE_SHIFT = pcpa_pkg::PAGE_SHIFT_DEF
)
(
    input  logic                           clk,
    input  logic                           rst_n,
    input  logic                           start,
    output logic                           busy,
    input  logic                           op,
    input  logic [pcpa_pkg::CPU_IN_W-1:0]  cpu,
    input  logic [pcpa_pkg::ADDR_W-1:0]    address,
    output logic                           done,
    output logic [pcpa_pkg::STATUS_W-1:0]  status,
    output logic [pcpa_pkg::ADDR_W-1:0]    page_address,
    input  logic                           cfg_write,
    input  logic [pcpa_pkg::CFG_IDX_W-1:0] cfg_index,
    input  logic [pcpa_pkg::CFG_W-1:0]     cfg_data
);

    pcpa_pkg::cmd_t cmd;
    pcpa_pkg::sts_t sts;

    pcpa_ctrl u_ctrl
    (
        .clk   (clk),
        .rst_n (rst_n),
        .start (start),
        .sts   (sts),
        .cmd   (cmd),
        .busy  (busy)
    );

    pcpa_datapath
    #(
        .NUM_CPUS   (NUM_CPUS),
        .NUM_PAGES  (NUM_PAGES),
        .PAGE_SHIFT (PAGE_SHIFT)
    )
    u_datapath
    (
        .clk          (clk),
        .rst_n        (rst_n),
        .cmd          (cmd),
        .sts          (sts),
        .op           (op),
        .cpu          (cpu),
        .address      (address),
        .cfg_write    (cfg_write),
        .cfg_index    (cfg_index),
        .cfg_data     (cfg_data),
        .done         (done),
        .status       (status),
        .page_address (page_address)
    );

endmodule

@@ sv/pcpa_ctrl.sv @@
// controller: request sequencing state machine of the page allocator
module pcpa_ctrl
(
    input  logic            clk,
    input  logic            rst_n,
    input  logic            start,
    input  pcpa_pkg::sts_t  sts,
    output pcpa_pkg::cmd_t  cmd,
    output logic            busy
);

    pcpa_pkg::state_t state_reg;
    pcpa_pkg::state_t state_next;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= pcpa_pkg::S_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    always_comb
    begin
        state_next = state_reg;
        cmd.take   = 1'b0;
        cmd.pop    = 1'b0;
        busy       = 1'b0;
        unique case (state_reg)
            pcpa_pkg::S_IDLE:
            begin
                cmd.take = start;
                if (start && sts.alloc_hit)
                begin
                    state_next = pcpa_pkg::S_POP;
                end
            end
            pcpa_pkg::S_POP:
            begin
                cmd.pop    = 1'b1;
                busy       = 1'b1;
                state_next = pcpa_pkg::S_IDLE;
            end
            default:
            begin
                state_next = pcpa_pkg::S_IDLE;
            end
        endcase
    end

endmodule

@@ sv/pcpa_datapath.sv @@
// datapath: config registers, list heads, link memory and result registers
module pcpa_datapath
#(
    parameter int NUM_CPUS   = pcpa_pkg::NUM_CPUS_DEF,
    parameter int NUM_PAGES  = pcpa_pkg::NUM_PAGES_DEF,
    parameter int PAGE_SHIFT = pcpa_pkg::PAGE_SHIFT_DEF
)
(
    input  logic                                clk,
    input  logic                                rst_n,
    input  pcpa_pkg::cmd_t                      cmd,
    output pcpa_pkg::sts_t                      sts,
    input  logic                                op,
    input  logic [pcpa_pkg::CPU_IN_W-1:0]       cpu,
    input  logic [pcpa_pkg::ADDR_W-1:0]         address,
    input  logic                                cfg_write,
    input  logic [pcpa_pkg::CFG_IDX_W-1:0]      cfg_index,
    input  logic [pcpa_pkg::CFG_W-1:0]          cfg_data,
    output logic                                done,
    output logic [pcpa_pkg::STATUS_W-1:0]       status,
    output logic [pcpa_pkg::ADDR_W-1:0]         page_address
);

    localparam int CPU_W  = (NUM_CPUS > 1) ? $clog2(NUM_CPUS) : 1;
    localparam int SLOT_W = $clog2(NUM_PAGES);
    localparam int HEAD_W = $clog2(NUM_PAGES + 1);
    localparam int PG_W   = pcpa_pkg::ADDR_W - PAGE_SHIFT;
    localparam int DIFF_W = ((PG_W > pcpa_pkg::TOP_W) ? PG_W : pcpa_pkg::TOP_W) + 1;
    localparam int MOD_W  = 7;

    logic [pcpa_pkg::BASE_W-1:0]   base_page_reg;
    logic [pcpa_pkg::TOP_W-1:0]    top_page_reg;
    logic [HEAD_W-1:0]             heads_reg [NUM_CPUS];
    logic [HEAD_W-1:0]             links_mem [NUM_PAGES];
    logic [HEAD_W-1:0]             link_rd_reg;
    logic [CPU_W-1:0]              victim_reg;
    logic [SLOT_W-1:0]             slot_reg;
    logic                          done_reg;
    logic [pcpa_pkg::STATUS_W-1:0] status_reg;
    logic [pcpa_pkg::ADDR_W-1:0]   page_address_reg;

    logic [MOD_W-1:0]    cpu_mod;
    logic [CPU_W-1:0]    cpu_eff;
    logic [NUM_CPUS-1:0] nonempty;
    logic                any_nonempty;
    logic [CPU_W-1:0]    first_cpu;
    logic [CPU_W-1:0]    victim;
    logic [HEAD_W-1:0]   victim_head;
    logic [SLOT_W-1:0]   pop_slot;
    logic [DIFF_W-1:0]   page_ext;
    logic [DIFF_W-1:0]   base_ext;
    logic [DIFF_W-1:0]   top_ext;
    logic [DIFF_W-1:0]   offset;
    logic                free_bad;
    logic [SLOT_W-1:0]   free_slot;
    logic                is_free;
    logic                do_push;
    logic                do_read;
    logic [pcpa_pkg::ADDR_W-1:0] page_sum;

    // requesting cpu wrapped into range
    always_comb
    begin
        cpu_mod = MOD_W'(cpu);
        for (int k = 0; k < 8; k++)
        begin
            if (cpu_mod >= MOD_W'(NUM_CPUS))
            begin
                cpu_mod = cpu_mod - MOD_W'(NUM_CPUS);
            end
        end
        cpu_eff = CPU_W'(cpu_mod);
    end

    // own list first, else lowest-numbered list holding a page
    always_comb
    begin
        first_cpu = '0;
        for (int i = NUM_CPUS - 1; i >= 0; i--)
        begin
            nonempty[i] = (heads_reg[i] != '0);
        end
        for (int i = NUM_CPUS - 1; i >= 0; i--)
        begin
            if (nonempty[i])
            begin
                first_cpu = CPU_W'(i);
            end
        end
        any_nonempty = |nonempty;
        victim       = nonempty[cpu_eff] ? cpu_eff : first_cpu;
        victim_head  = heads_reg[victim];
        pop_slot     = SLOT_W'(victim_head - HEAD_W'(1));
    end

    // free address check
    always_comb
    begin
        page_ext  = DIFF_W'(address[pcpa_pkg::ADDR_W-1:PAGE_SHIFT]);
        base_ext  = DIFF_W'(base_page_reg);
        top_ext   = DIFF_W'(top_page_reg);
        offset    = page_ext - base_ext;
        free_bad  = (address[PAGE_SHIFT-1:0] != '0) || (page_ext < base_ext) ||
                    (page_ext >= top_ext) || (offset >= DIFF_W'(NUM_PAGES));
        free_slot = offset[SLOT_W-1:0];
    end

    assign is_free       = (op == pcpa_pkg::OP_FREE);
    assign sts.alloc_hit = !is_free && any_nonempty;
    assign do_push       = cmd.take && is_free && !free_bad;
    assign do_read       = cmd.take && sts.alloc_hit;
    assign page_sum      = pcpa_pkg::ADDR_W'(base_page_reg) + pcpa_pkg::ADDR_W'(slot_reg);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            base_page_reg <= '0;
            top_page_reg  <= '0;
            done_reg      <= 1'b0;
            for (int i = 0; i < NUM_CPUS; i++)
            begin
                heads_reg[i] <= '0;
            end
        end
        else
        begin
            if (cfg_write)
            begin
                unique case (cfg_index)
                    pcpa_pkg::CFG_BASE_PAGE: base_page_reg <= cfg_data[pcpa_pkg::BASE_W-1:0];
                    pcpa_pkg::CFG_TOP_PAGE:  top_page_reg  <= cfg_data[pcpa_pkg::TOP_W-1:0];
                    default: ;
                endcase
            end
            done_reg <= (cmd.take && !sts.alloc_hit) || cmd.pop;
            if (do_push)
            begin
                heads_reg[cpu_eff] <= HEAD_W'(free_slot) + HEAD_W'(1);
            end
            else if (cmd.pop)
            begin
                heads_reg[victim_reg] <= link_rd_reg;
            end
        end
    end

    // link memory
    always_ff @(posedge clk)
    begin
        if (do_push)
        begin
            links_mem[free_slot] <= heads_reg[cpu_eff];
        end
        if (do_read)
        begin
            link_rd_reg <= links_mem[pop_slot];
        end
    end

    always_ff @(posedge clk)
    begin
        if (do_read)
        begin
            victim_reg <= victim;
            slot_reg   <= pop_slot;
        end
        if (cmd.pop)
        begin
            status_reg       <= pcpa_pkg::STATUS_OK;
            page_address_reg <= page_sum << PAGE_SHIFT;
        end
        else if (cmd.take)
        begin
            page_address_reg <= '0;
            if (is_free)
            begin
                status_reg <= free_bad ? pcpa_pkg::STATUS_BADADDR : pcpa_pkg::STATUS_OK;
            end
            else
            begin
                status_reg <= pcpa_pkg::STATUS_NOMEM;
            end
        end
    end

    assign done         = done_reg;
    assign status       = status_reg;
    assign page_address = page_address_reg;

endmodule

@@ sv/pcpa_check.sv @@
// checker: port-level assertions of the page allocator and its bind
`include "per_cpu_page_allocator_assert.svh"

module pcpa_check
(
    input logic                          clk,
    input logic                          rst_n,
    input logic                          start,
    input logic                          busy,
    input logic                          op,
    input logic                          done,
    input logic [pcpa_pkg::STATUS_W-1:0] status,
    input logic [pcpa_pkg::ADDR_W-1:0]   page_address
);

    logic free_xfer;
    logic alloc_xfer;
    logic free_res_ok;
    logic alloc_next_ok;
    logic err_result;

    assign free_xfer     = start && !busy && (op == pcpa_pkg::OP_FREE);
    assign alloc_xfer    = start && !busy && (op == pcpa_pkg::OP_ALLOC);
    assign free_res_ok   = done && !busy && (status != pcpa_pkg::STATUS_NOMEM);
    assign alloc_next_ok = busy || (done && (status == pcpa_pkg::STATUS_NOMEM));
    assign err_result    = done && (status != pcpa_pkg::STATUS_OK);

    `PCPA_ASSERT_NEXT(a_pop_done, busy, done && !busy, "pop did not deliver a result")
    `PCPA_ASSERT_NEXT(a_free_result, free_xfer, free_res_ok, "free transfer gave no proper result")
    `PCPA_ASSERT_NEXT(a_alloc_path, alloc_xfer, alloc_next_ok, "allocate neither popped nor failed")
    `PCPA_ASSERT_NOW(a_err_zero, err_result, page_address == '0, "error result with nonzero page")

endmodule

bind per_cpu_page_allocator pcpa_check u_pcpa_check (.*);

@@ dv/per_cpu_page_allocator_test.sv @@
// self-checking testbench for the per-cpu page allocator: directed table, then random traffic
`timescale 1ns / 100ps

module per_cpu_page_allocator_test;
    import pcpa_pkg::*;

    localparam int NUM_CPUS = NUM_CPUS_DEF;
    localparam int NUM_PAGES = NUM_PAGES_DEF;
    localparam int PAGE_SHIFT = PAGE_SHIFT_DEF;
    localparam int CPU_IDX_W = (NUM_CPUS > 1) ? $clog2(NUM_CPUS) : 1;
    localparam int SLOT_IDX_W = $clog2(NUM_PAGES);
    localparam int CYCLE_LIMIT = 1000000;
    localparam int PLAN_ROWS = 30;
    localparam int NUM_WINDOWS = 7;
    localparam int WIN_IDX_W = $clog2(NUM_WINDOWS);
    localparam int ITEMS_PER_WINDOW = 270;
    localparam int POOL_MAX = 64;
    localparam int MAX_PRINTS = 40;

    typedef enum logic
    {
        ROW_REQ,
        ROW_CFG
    } row_kind_t;

    typedef struct packed
    {
        row_kind_t             kind;
        logic [CFG_IDX_W-1:0]  cfg_idx;
        op_t                   op;
        logic [CPU_IN_W-1:0]   cpu;
        logic [ADDR_W-1:0]     data;
        logic                  typed;
        logic [STATUS_W-1:0]   status;
        logic [ADDR_W-1:0]     page_address;
    } plan_row_t;

    typedef struct packed
    {
        logic [STATUS_W-1:0] status;
        logic [ADDR_W-1:0]   page_address;
    } alloc_result_t;

    logic                   clk;
    logic                   rst_n;
    logic                   start;
    logic                   busy;
    logic                   op;
    logic [CPU_IN_W-1:0]    cpu;
    logic [ADDR_W-1:0]      address;
    logic                   done;
    logic [STATUS_W-1:0]    status;
    logic [ADDR_W-1:0]      page_address;
    logic                   cfg_write;
    logic [CFG_IDX_W-1:0]   cfg_index;
    logic [CFG_W-1:0]       cfg_data;

    // predictor state
    logic [10:0]            list_head [NUM_CPUS];
    logic [10:0]            link_of [NUM_PAGES];
    logic [BASE_W-1:0]      base_reg;
    logic [TOP_W-1:0]       top_reg;

    alloc_result_t          pending_results [$];
    logic [ADDR_W-1:0]      held_pages [$];
    plan_row_t              plan [PLAN_ROWS];

    int                     errors;
    int                     cycle_count;
    bit                     steady;
    int                     n_alloc;
    int                     n_free;
    int                     n_ok;
    int                     n_nomem;
    int                     n_bad;
    int                     n_steal;
    int                     n_windows;

    per_cpu_page_allocator i_dut
    (
        .clk          (clk),
        .rst_n        (rst_n),
        .start        (start),
        .busy         (busy),
        .op           (op),
        .cpu          (cpu),
        .address      (address),
        .done         (done),
        .status       (status),
        .page_address (page_address),
        .cfg_write    (cfg_write),
        .cfg_index    (cfg_index),
        .cfg_data     (cfg_data)
    );

    initial
    begin
        clk = 1'b0;
        forever
        begin
            #5 clk = ~clk;
        end
    end

    always @(posedge clk)
    begin
        cycle_count++;
        if (cycle_count == CYCLE_LIMIT)
        begin
            $display("timeout after %0d cycles, %0d results outstanding",
                     cycle_count, pending_results.size());
            $display("status: fail");
            $finish;
        end
    end

    task automatic report_mismatch(input string msg);
        errors++;
        if (errors <= MAX_PRINTS)
            $display("%0t mismatch: %s", $realtime, msg);
    endtask

    // result checker
    always @(posedge clk)
    begin
        alloc_result_t want;
        if (rst_n && done)
        begin
            if (pending_results.size() == 0)
            begin
                report_mismatch($sformatf("unexpected result status %0d page %h",
                                          status, page_address));
            end
            else
            begin
                want = pending_results.pop_front();
                if (status !== want.status)
                    report_mismatch($sformatf("status got %0d want %0d",
                                              status, want.status));
                if (page_address !== want.page_address)
                    report_mismatch($sformatf("page_address got %h want %h",
                                              page_address, want.page_address));
                case (want.status)
                    STATUS_OK:    n_ok++;
                    STATUS_NOMEM: n_nomem++;
                    default:      n_bad++;
                endcase
            end
        end
    end

    function automatic bit pop_list(input int unsigned c, output int unsigned slot);
        if (list_head[CPU_IDX_W'(c)] == 0 || list_head[CPU_IDX_W'(c)] > NUM_PAGES)
            return 1'b0;
        slot = list_head[CPU_IDX_W'(c)] - 1;
        list_head[CPU_IDX_W'(c)] = link_of[SLOT_IDX_W'(slot)];
        return 1'b1;
    endfunction

    function automatic void serve_request(input op_t o, input logic [CPU_IN_W-1:0] c_in,
                                          input logic [ADDR_W-1:0] a,
                                          output logic [STATUS_W-1:0] st,
                                          output logic [ADDR_W-1:0] pa);
        logic [63:0]  page;
        logic [63:0]  full;
        int unsigned  c;
        int unsigned  slot;
        int unsigned  i;
        bit           got;
        c = c_in % NUM_CPUS;
        st = STATUS_OK;
        pa = '0;
        slot = 0;
        if (o == OP_FREE)
        begin
            page = {32'b0, a} >> PAGE_SHIFT;
            if (a[PAGE_SHIFT-1:0] != '0 || page < base_reg || page >= top_reg ||
                page - base_reg >= NUM_PAGES)
            begin
                st = STATUS_BADADDR;
            end
            else
            begin
                slot = int'(page - base_reg);
                link_of[SLOT_IDX_W'(slot)] = list_head[CPU_IDX_W'(c)];
                list_head[CPU_IDX_W'(c)] = 11'(slot + 1);
            end
        end
        else
        begin
            got = pop_list(c, slot);
            for (i = 0; !got && i < NUM_CPUS; i++)
            begin
                if (i != c)
                begin
                    got = pop_list(i, slot);
                    if (got)
                        n_steal++;
                end
            end
            if (got)
            begin
                full = (64'(base_reg) + 64'(slot)) << PAGE_SHIFT;
                pa = full[ADDR_W-1:0];
            end
            else
            begin
                st = STATUS_NOMEM;
            end
        end
    endfunction

    function automatic int pick_gap();
        int unsigned r;
        if (steady)
            return 0;
        r = $urandom_range(99);
        if (r < 45)
            return 0;
        if (r < 85)
            return $urandom_range(1, 3);
        if (r < 97)
            return $urandom_range(4, 12);
        return $urandom_range(20, 60);
    endfunction

    task automatic send_request(input op_t o, input logic [CPU_IN_W-1:0] c,
                                input logic [ADDR_W-1:0] a, input bit typed,
                                input logic [STATUS_W-1:0] st_typed,
                                input logic [ADDR_W-1:0] pa_typed);
        int            gap;
        alloc_result_t r;
        gap = pick_gap();
        if (gap > 0)
        begin
            @(negedge clk);
            start <= 1'b0;
            repeat (gap - 1) @(negedge clk);
        end
        @(negedge clk);
        start <= 1'b1;
        op <= o;
        cpu <= c;
        address <= a;
        do @(posedge clk); while (busy);
        // transfer taken at this edge
        serve_request(o, c, a, r.status, r.page_address);
        if (o == OP_ALLOC)
        begin
            n_alloc++;
            if (r.status == STATUS_OK && held_pages.size() < POOL_MAX)
                held_pages.push_back(r.page_address);
        end
        else
        begin
            n_free++;
        end
        if (typed)
        begin
            r.status = st_typed;
            r.page_address = pa_typed;
        end
        pending_results.push_back(r);
    endtask

    task automatic drain();
        @(negedge clk);
        start <= 1'b0;
        while (pending_results.size() != 0) @(posedge clk);
        repeat (4) @(posedge clk);
    endtask

    task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_W-1:0] value);
        @(negedge clk);
        cfg_write <= 1'b1;
        cfg_index <= idx;
        cfg_data <= value;
        if (idx == CFG_BASE_PAGE)
            base_reg = value[BASE_W-1:0];
        else
            top_reg = value[TOP_W-1:0];
        @(negedge clk);
        cfg_write <= 1'b0;
    endtask

    task automatic set_window(input logic [BASE_W-1:0] b, input logic [TOP_W-1:0] t);
        logic [CFG_W-1:0] base_word;
        drain();
        // upper bit of the base word is don't-care
        base_word = {1'($urandom_range(1)), b};
        if ($urandom_range(1) == 0)
        begin
            write_reg(CFG_BASE_PAGE, base_word);
            write_reg(CFG_TOP_PAGE, t);
        end
        else
        begin
            write_reg(CFG_TOP_PAGE, t);
            write_reg(CFG_BASE_PAGE, base_word);
        end
        n_windows++;
    endtask

    task automatic next_random_request(output op_t o, output logic [CPU_IN_W-1:0] c,
                                       output logic [ADDR_W-1:0] a);
        int unsigned   r;
        int unsigned   span;
        int unsigned   k;
        logic [31:0]   page;
        c = CPU_IN_W'($urandom_range(7));
        a = $urandom;
        o = OP_FREE;
        if ($urandom_range(99) < 45)
        begin
            o = OP_ALLOC;
            return;
        end
        span = (top_reg > base_reg) ? 32'(top_reg) - 32'(base_reg) : 0;
        if (span > NUM_PAGES)
            span = NUM_PAGES;
        r = $urandom_range(99);
        if (r < 55 && held_pages.size() > 0)
        begin
            k = $urandom_range(held_pages.size() - 1);
            a = held_pages[k];
            held_pages.delete(k);
        end
        else if (r < 80 && span > 0)
        begin
            page = 32'(base_reg) + $urandom_range(span - 1);
            a = page << PAGE_SHIFT;
        end
        else if (r < 92)
        begin
            // near misses around the window edges
            case ($urandom_range(3))
                0: page = 32'(base_reg) - 1;
                1: page = 32'(top_reg);
                2: page = 32'(base_reg) + NUM_PAGES;
                default: page = 32'(base_reg);
            endcase
            a = page << PAGE_SHIFT;
            if ($urandom_range(3) == 0)
                a[PAGE_SHIFT-1:0] = PAGE_SHIFT'($urandom_range(1, (1 << PAGE_SHIFT) - 1));
        end
    endtask

    initial
    begin
        op_t                   o;
        logic [CPU_IN_W-1:0]   c;
        logic [ADDR_W-1:0]     a;
        logic [BASE_W-1:0]     win_base [NUM_WINDOWS];
        logic [TOP_W-1:0]      win_top [NUM_WINDOWS];
        int unsigned           rb;
        int unsigned           rt;

        rst_n = 1'b0;
        start = 1'b0;
        op = OP_ALLOC;
        cpu = '0;
        address = '0;
        cfg_write = 1'b0;
        cfg_index = CFG_BASE_PAGE;
        cfg_data = '0;
        errors = 0;
        cycle_count = 0;
        steady = 1'b0;
        n_alloc = 0;
        n_free = 0;
        n_ok = 0;
        n_nomem = 0;
        n_bad = 0;
        n_steal = 0;
        n_windows = 0;
        base_reg = '0;
        top_reg = '0;
        foreach (list_head[i])
            list_head[i] = '0;
        foreach (link_of[i])
            link_of[i] = '0;

        plan = '{
            '{ROW_REQ, CFG_BASE_PAGE, OP_ALLOC, 3'd0, 32'h0000_0000, 1'b1, STATUS_NOMEM,   32'h0},
            '{ROW_REQ, CFG_BASE_PAGE, OP_FREE,  3'd0, 32'h0000_0000, 1'b1, STATUS_BADADDR, 32'h0},
            '{ROW_CFG, CFG_BASE_PAGE, OP_ALLOC, 3'd0, 32'h0000_0100, 1'b0, STATUS_OK,      32'h0},
            '{ROW_CFG, CFG_TOP_PAGE,  OP_ALLOC, 3'd0, 32'h0000_0500, 1'b0, STATUS_OK,      32'h0},
            // misaligned, below base, at top
            '{ROW_REQ, CFG_BASE_PAGE, OP_FREE,  3'd0, 32'h0010_0001, 1'b1, STATUS_BADADDR, 32'h0},
            '{ROW_REQ, CFG_BASE_PAGE, OP_FREE,  3'd1, 32'h000F_F000, 1'b1, STATUS_BADADDR, 32'h0},
            '{ROW_REQ, CFG_BASE_PAGE, OP_FREE,  3'd1, 32'h0050_0000, 1'b1, STATUS_BADADDR, 32'h0},
            '{ROW_REQ, CFG_BASE_PAGE, OP_FREE,  3'd2, 32'h0010_0000, 1'b1, STATUS_OK,      32'h0},
            '{ROW_REQ, CFG_BASE_PAGE, OP_FREE,  3'd2, 32'h004F_F000, 1'b1, STATUS_OK,      32'h0},
            '{ROW_REQ, CFG_BASE_PAGE, OP_FREE,  3'd7, 32'h0020_0000, 1'b1, STATUS_OK,      32'h0},
            '{ROW_REQ, CFG_BASE_PAGE, OP_ALLOC, 3'd2, 32'hFFFF_FFFF, 1'b1, STATUS_OK,
              32'h004F_F000},
            // empty own list, steal from lowest other
            '{ROW_REQ, CFG_BASE_PAGE, OP_ALLOC, 3'd5, 32'h0000_0000, 1'b0, STATUS_OK,      32'h0},
            '{ROW_REQ, CFG_BASE_PAGE, OP_ALLOC, 3'd3, 32'h0000_0000, 1'b0, STATUS_OK,      32'h0},
            '{ROW_REQ, CFG_BASE_PAGE, OP_ALLOC, 3'd0, 32'hFFFF_FFFF, 1'b1, STATUS_NOMEM,   32'h0},
            // double free onto two lists
            '{ROW_REQ, CFG_BASE_PAGE, OP_FREE,  3'd7, 32'h0030_0000, 1'b1, STATUS_OK,      32'h0},
            '{ROW_REQ, CFG_BASE_PAGE, OP_FREE,  3'd6, 32'h0030_0000, 1'b1, STATUS_OK,      32'h0},
            '{ROW_REQ, CFG_BASE_PAGE, OP_ALLOC, 3'd6, 32'h0000_0000, 1'b0, STATUS_OK,      32'h0},
            '{ROW_REQ, CFG_BASE_PAGE, OP_ALLOC, 3'd7, 32'h0000_0000, 1'b0, STATUS_OK,      32'h0},
            '{ROW_REQ, CFG_BASE_PAGE, OP_FREE,  3'd4, 32'hFFFF_F000, 1'b1, STATUS_BADADDR, 32'h0},
            '{ROW_CFG, CFG_TOP_PAGE,  OP_ALLOC, 3'd0, 32'h0010_0000, 1'b0, STATUS_OK,      32'h0},
            '{ROW_CFG, CFG_BASE_PAGE, OP_ALLOC, 3'd0, 32'h0000_0000, 1'b0, STATUS_OK,      32'h0},
            // page beyond store, then last slot
            '{ROW_REQ, CFG_BASE_PAGE, OP_FREE,  3'd0, 32'h0040_0000, 1'b1, STATUS_BADADDR, 32'h0},
            '{ROW_REQ, CFG_BASE_PAGE, OP_FREE,  3'd0, 32'h003F_F000, 1'b1, STATUS_OK,      32'h0},
            '{ROW_REQ, CFG_BASE_PAGE, OP_FREE,  3'd3, 32'h0000_0000, 1'b1, STATUS_OK,      32'h0},
            // base moved with pages listed, address wraps
            '{ROW_CFG, CFG_BASE_PAGE, OP_ALLOC, 3'd0, 32'h000F_FFFF, 1'b0, STATUS_OK,      32'h0},
            '{ROW_REQ, CFG_BASE_PAGE, OP_ALLOC, 3'd0, 32'h0000_0000, 1'b0, STATUS_OK,      32'h0},
            '{ROW_REQ, CFG_BASE_PAGE, OP_ALLOC, 3'd1, 32'h0000_0000, 1'b1, STATUS_OK,
              32'hFFFF_F000},
            '{ROW_REQ, CFG_BASE_PAGE, OP_FREE,  3'd6, 32'hFFFF_F000, 1'b1, STATUS_OK,      32'h0},
            '{ROW_REQ, CFG_BASE_PAGE, OP_FREE,  3'd5, 32'h0000_1000, 1'b1, STATUS_BADADDR, 32'h0},
            '{ROW_REQ, CFG_BASE_PAGE, OP_ALLOC, 3'd6, 32'h0000_0000, 1'b1, STATUS_OK,
              32'hFFFF_F000}
        };

        repeat (3) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;

        foreach (plan[i])
        begin
            if (plan[i].kind == ROW_CFG)
            begin
                drain();
                write_reg(plan[i].cfg_idx, plan[i].data[CFG_W-1:0]);
                n_windows++;
            end
            else
            begin
                send_request(plan[i].op, plan[i].cpu, plan[i].data, plan[i].typed,
                             plan[i].status, plan[i].page_address);
            end
        end

        win_base = '{20'h00010, 20'h00000, 20'hFFC00, 20'h00000, 20'hFFFFF, 20'h00200, 20'h0};
        win_top = '{21'h00410, 21'h100000, 21'h100000, 21'h0, 21'h100000, 21'h00100, 21'h0};
        // two windows drawn at random
        for (int w = 3; w < NUM_WINDOWS; w += 3)
        begin
            rb = $urandom_range(0, 20'hFFFFF);
            rt = rb + $urandom_range(1, 1100);
            if (rt > 21'h100000)
                rt = 21'h100000;
            win_base[WIN_IDX_W'(w)] = BASE_W'(rb);
            win_top[WIN_IDX_W'(w)] = TOP_W'(rt);
        end

        for (int w = 0; w < NUM_WINDOWS; w++)
        begin
            set_window(win_base[WIN_IDX_W'(w)], win_top[WIN_IDX_W'(w)]);
            for (int n = 0; n < ITEMS_PER_WINDOW; n++)
            begin
                if (n % 40 == 0)
                    steady = ($urandom_range(3) == 0);
                if ($urandom_range(199) == 0)
                    drain();
                next_random_request(o, c, a);
                send_request(o, c, a, 1'b0, STATUS_OK, '0);
            end
        end

        drain();
        repeat (10) @(posedge clk);

        $display("covered %0d transfers (%0d alloc, %0d free) across %0d register settings",
                 n_alloc + n_free, n_alloc, n_free, n_windows);
        $display("outcomes: %0d ok, %0d out of memory, %0d bad address, %0d stolen pages",
                 n_ok, n_nomem, n_bad, n_steal);
        if (errors == 0)
            $display("status: pass");
        else
            $display("status: fail");
        $finish;
    end

endmodule

@@ filelist.f @@
+incdir+sv
sv/pcpa_pkg.sv
sv/pcpa_ctrl.sv
sv/pcpa_datapath.sv
sv/per_cpu_page_allocator.sv
sv/pcpa_check.sv
dv/per_cpu_page_allocator_test.sv
